FILE: sv/pmsc_pkg.sv
// Shared types, constants and helpers of the page mode sprite compositor.
package pmsc_pkg;

  // Tile memory geometry: depth is a power of two so address wrap is a truncation.
  localparam int TMEM_AW        = 12;
  localparam int TILE_MEM_DEPTH = 1 << TMEM_AW;

  // Screen geometry; counter widths follow the result fields.
  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int COL_W   = 7;
  localparam int PAGE_W  = 3;

  // Operation queue between front and back.
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

  // Result queue depth is fixed at two entries.
  localparam int RESQ_DEPTH = 2;

  // Input command codes.
  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_DRAW      = 2'd1;
  localparam logic [1:0] CMD_END_LAYER = 2'd2;
  localparam logic [1:0] CMD_END_COL   = 2'd3;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_SKIP,
    OP_DRAW,
    OP_FOLD,
    OP_EMIT
  } op_kind_t;

  typedef enum logic [1:0] {
    RD_BITMAP,
    RD_MASK,
    RD_ODD
  } rd_tag_t;

  typedef enum logic {
    BK_IDLE,
    BK_FETCH
  } bk_state_t;

  // One input item as seen on the ports.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] address;
    logic [7:0]  data;
    logic [3:0]  tile_width;
    logic        has_mask;
    logic        transparent;
    logic        has_odd_bitmap;
    logic        flip_x;
    logic        flip_y;
    logic        invert;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
  } in_item_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    op_kind_t            kind;
    logic [TMEM_AW-1:0]  addr;       // write address or bitmap address
    logic [7:0]          data;
    logic [TMEM_AW-1:0]  mask_addr;
    logic [TMEM_AW-1:0]  odd_addr;
    logic                has_mask;
    logic                transparent;
    logic                use_odd;
    logic                flip_y;
    logic                invert;
    logic                top;
    logic [2:0]          shift;
    logic [PAGE_W-1:0]   page;
    logic [COL_W-1:0]    column;
    logic                frame_end;
  } op_t;

  typedef struct packed {
    logic [7:0]        pixel_byte;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
    logic              frame_end;
  } res_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

FILE: sv/pmsc_ram.sv
// Generic single-port RAM with registered read data.
module pmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/pmsc_front.sv
// Front end: classifies input items and tracks column, page and frame parity.
module pmsc_front
  import pmsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output op_t      op
);

  logic [COL_W-1:0]  col_r,  col_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              odd_r,  odd_nxt;

  logic [8:0]         col9, px9, px_end9, off9;
  logic [3:0]         off, idx;
  logic               covers_x;
  logic [8:0]         page_y9, py9;
  logic               top_hit, bot_hit;
  logic [TMEM_AW-1:0] bm_addr, mk_addr;
  logic               last_col, last_page;

  // Horizontal coverage and tile column index.
  always_comb begin
    col9     = {2'b00, col_r};
    px9      = {1'b0, item.pos_x};
    px_end9  = px9 + {5'b00000, item.tile_width};
    covers_x = (col9 >= px9) && (col9 < px_end9);
    off9     = col9 - px9;
    off      = off9[3:0];
    idx      = item.flip_x ? (item.tile_width - 4'd1 - off) : off;
    bm_addr  = TMEM_AW'(item.address) + TMEM_AW'(idx);
    mk_addr  = bm_addr + TMEM_AW'(item.tile_width);
  end

  // Vertical placement: tile starts in this page, or spills in from the page above.
  always_comb begin
    page_y9 = {3'b000, page_r, 3'b000};
    py9     = {1'b0, item.pos_y};
    top_hit = item.pos_y[7:3] == {2'b00, page_r};
    bot_hit = (page_y9 >= py9) && (page_y9 < py9 + 9'd8);
  end

  assign last_col  = col_r == COL_W'(COLUMNS - 1);
  assign last_page = page_r == PAGE_W'(PAGES - 1);

  always_comb begin
    op             = '0;
    op.kind        = OP_SKIP;
    op.addr        = TMEM_AW'(item.address);
    op.data        = item.data;
    op.mask_addr   = mk_addr;
    op.odd_addr    = item.has_mask ? (mk_addr + TMEM_AW'(item.tile_width)) : mk_addr;
    op.has_mask    = item.has_mask;
    op.transparent = item.transparent;
    op.use_odd     = item.has_odd_bitmap && odd_r;
    op.flip_y      = item.flip_y;
    op.invert      = item.invert;
    op.top         = top_hit;
    op.shift       = top_hit ? item.pos_y[2:0] : 3'(page_y9 - py9);
    op.page        = page_r;
    op.column      = col_r;
    op.frame_end   = last_col && last_page;
    unique case (item.cmd)
      CMD_WRITE:     op.kind = OP_WRITE;
      CMD_DRAW: begin
        op.kind = OP_SKIP;
        if (covers_x && (top_hit || bot_hit)) begin
          op.kind = OP_DRAW;
          op.addr = bm_addr;
        end
      end
      CMD_END_LAYER: op.kind = OP_FOLD;
      CMD_END_COL:   op.kind = OP_EMIT;
      default:       op.kind = OP_SKIP;
    endcase
  end

  // Advance position on every accepted end-column item.
  always_comb begin
    col_nxt  = col_r;
    page_nxt = page_r;
    odd_nxt  = odd_r;
    if (accept && item.cmd == CMD_END_COL) begin
      col_nxt = last_col ? '0 : col_r + 1'b1;
      if (last_col) begin
        page_nxt = last_page ? '0 : page_r + 1'b1;
        if (last_page) begin
          odd_nxt = ~odd_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      page_r <= '0;
      odd_r  <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      page_r <= page_nxt;
      odd_r  <= odd_nxt;
    end
  end

endmodule

FILE: sv/pmsc_opq.sv
// Short operation queue between the front and the back.
module pmsc_opq
  import pmsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  op_t  wr_op,
  output logic full,
  input  logic rd_en,
  output logic head_valid,
  output op_t  head
);

  op_t               q_r [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wptr_r, wptr_nxt;
  logic [OPQ_AW-1:0] rptr_r, rptr_nxt;
  logic [OPQ_AW:0]   cnt_r,  cnt_nxt;
  logic              do_wr, do_rd;

  assign full       = cnt_r == (OPQ_AW + 1)'(OPQ_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = q_r[rptr_r];
  assign do_wr      = wr_en && !full;
  assign do_rd      = rd_en && head_valid;

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: sv/pmsc_back.sv
// Back end: tile memory, fetch sequencer, layer merge and result queue.
module pmsc_back
  import pmsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  op_t  head,
  output logic head_pop,
  input  logic res_pop,
  output logic res_empty,
  output res_t res
);

  bk_state_t state_r, state_nxt;
  rd_tag_t   tag_r,   tag_nxt;
  op_t       draw_r,  draw_nxt;
  logic [7:0] b_r, b_nxt, m_r, m_nxt;
  logic [7:0] composed_r, composed_nxt;
  logic [7:0] bits_r, bits_nxt;
  logic [7:0] lmask_r, lmask_nxt;

  logic               ram_we;
  logic [TMEM_AW-1:0] ram_addr;
  logic [7:0]         ram_wdata, ram_rdata;

  logic [7:0] b_cur, m_cur, bf, mf, sb, sm;
  logic       merge;

  // Result queue.
  res_t       rq_r [RESQ_DEPTH];
  logic       rq_wptr_r, rq_rptr_r;
  logic [1:0] rq_cnt_r, rq_cnt_nxt;
  logic       rq_push, rq_pop, rq_full;
  res_t       rq_in;

  pmsc_ram #(
    .WIDTH (8),
    .DEPTH (TILE_MEM_DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Fold the returning byte into the working bitmap and mask.
  always_comb begin
    b_cur = b_r;
    m_cur = m_r;
    unique case (tag_r)
      RD_BITMAP: begin
        b_cur = ram_rdata;
        m_cur = draw_r.transparent ? ram_rdata : BYTE_ONES;
      end
      RD_MASK:  m_cur = ram_rdata;
      RD_ODD:   b_cur = ram_rdata;
      default: begin
        b_cur = b_r;
        m_cur = m_r;
      end
    endcase
    bf = draw_r.flip_y ? bit_rev8(b_cur) : b_cur;
    mf = draw_r.flip_y ? bit_rev8(m_cur) : m_cur;
    if (draw_r.invert) begin
      bf = ~bf & mf;
    end
    sb = draw_r.top ? (bf << draw_r.shift) : (bf >> draw_r.shift);
    sm = draw_r.top ? (mf << draw_r.shift) : (mf >> draw_r.shift);
  end

  assign rq_full = rq_cnt_r == 2'(RESQ_DEPTH);

  always_comb begin
    state_nxt    = state_r;
    tag_nxt      = tag_r;
    draw_nxt     = draw_r;
    b_nxt        = b_r;
    m_nxt        = m_r;
    composed_nxt = composed_r;
    bits_nxt     = bits_r;
    lmask_nxt    = lmask_r;
    head_pop     = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = head.addr;
    ram_wdata    = head.data;
    rq_push      = 1'b0;
    merge        = 1'b0;
    rq_in.pixel_byte = (composed_r & lmask_r) | bits_r;
    rq_in.page       = head.page;
    rq_in.column     = head.column;
    rq_in.frame_end  = head.frame_end;

    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          unique case (head.kind)
            OP_WRITE: begin
              ram_we   = 1'b1;
              head_pop = 1'b1;
            end
            OP_DRAW: begin
              draw_nxt  = head;
              tag_nxt   = RD_BITMAP;
              state_nxt = BK_FETCH;
              head_pop  = 1'b1;
            end
            OP_FOLD: begin
              composed_nxt = (composed_r & lmask_r) | bits_r;
              bits_nxt     = '0;
              lmask_nxt    = BYTE_ONES;
              head_pop     = 1'b1;
            end
            OP_EMIT: begin
              if (!rq_full) begin
                rq_push      = 1'b1;
                composed_nxt = '0;
                bits_nxt     = '0;
                lmask_nxt    = BYTE_ONES;
                head_pop     = 1'b1;
              end
            end
            default: head_pop = 1'b1;
          endcase
        end
      end
      BK_FETCH: begin
        b_nxt = b_cur;
        m_nxt = m_cur;
        unique case (tag_r)
          RD_BITMAP: begin
            if (draw_r.has_mask) begin
              ram_addr = draw_r.mask_addr;
              tag_nxt  = RD_MASK;
            end else if (draw_r.use_odd) begin
              ram_addr = draw_r.odd_addr;
              tag_nxt  = RD_ODD;
            end else begin
              merge = 1'b1;
            end
          end
          RD_MASK: begin
            if (draw_r.use_odd) begin
              ram_addr = draw_r.odd_addr;
              tag_nxt  = RD_ODD;
            end else begin
              merge = 1'b1;
            end
          end
          default: merge = 1'b1;
        endcase
        if (merge) begin
          bits_nxt  = bits_r | sb;
          lmask_nxt = lmask_r & ~sm;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Result queue bookkeeping.
  assign rq_pop    = res_pop && (rq_cnt_r != '0);
  assign res_empty = rq_cnt_r == '0;
  assign res       = rq_r[rq_rptr_r];

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (rq_push && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + 1'b1;
    end else if (rq_pop && !rq_push) begin
      rq_cnt_nxt = rq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wptr_r] <= rq_in;
    end
    draw_r <= draw_nxt;
    b_r    <= b_nxt;
    m_r    <= m_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      tag_r      <= RD_BITMAP;
      composed_r <= '0;
      bits_r     <= '0;
      lmask_r    <= BYTE_ONES;
      rq_wptr_r  <= 1'b0;
      rq_rptr_r  <= 1'b0;
      rq_cnt_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      tag_r      <= tag_nxt;
      composed_r <= composed_nxt;
      bits_r     <= bits_nxt;
      lmask_r    <= lmask_nxt;
      rq_wptr_r  <= rq_push ? ~rq_wptr_r : rq_wptr_r;
      rq_rptr_r  <= rq_pop ? ~rq_rptr_r : rq_rptr_r;
      rq_cnt_r   <= rq_cnt_nxt;
    end
  end

endmodule

FILE: sv/page_mode_sprite_compositor.sv
// Top level of the page mode sprite compositor.
//
// Input channel (queue style): present an item on the in_ ports with in_push
// high; it is taken at a rising edge where in_full is low. The front end
// decodes it at once against its own copy of column, page and frame parity,
// and writes one operation into a four-entry queue.
// The back end takes one operation a cycle from that queue while idle and, for
// an end column, while the result queue has room: a tile write, an uncovered
// draw, an end layer or an end column is handled as it is taken; a covered draw
// holds it for its tile memory reads (bitmap, then stored mask, then odd-frame
// bitmap), made in turn through the single port of the tile memory, then merges.
// Result channel: while out_empty is low the oldest byte with its page, column
// and frame-end flag is on the out_ ports; out_pop takes it. An end-column
// item is stored in the operation queue, then its byte in the result queue.
// A two-entry result queue keeps the back end busy while the receiver stalls;
// when it fills, end-column work holds and the operation queue backs up into
// in_full.
// Reset clears position, parity, layer and composed byte and empties both
// queues. Tile memory holds no reset value; write it before drawing from it.
module page_mode_sprite_compositor
  import pmsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [3:0]  in_tile_width,
  input  logic        in_has_mask,
  input  logic        in_transparent,
  input  logic        in_has_odd_bitmap,
  input  logic        in_flip_x,
  input  logic        in_flip_y,
  input  logic        in_invert,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_pixel_byte,
  output logic [2:0]  out_page,
  output logic [6:0]  out_column,
  output logic        out_frame_end
);

  in_item_t item;
  op_t      fe_op;
  op_t      head;
  logic     accept;
  logic     head_valid;
  logic     head_pop;
  res_t     res;

  // Gather the item fields into one word for the front end.
  always_comb begin
    item.cmd            = in_cmd;
    item.address        = in_address;
    item.data           = in_data;
    item.tile_width     = in_tile_width;
    item.has_mask       = in_has_mask;
    item.transparent    = in_transparent;
    item.has_odd_bitmap = in_has_odd_bitmap;
    item.flip_x         = in_flip_x;
    item.flip_y         = in_flip_y;
    item.invert         = in_invert;
    item.pos_x          = in_pos_x;
    item.pos_y          = in_pos_y;
  end

  // An item is taken whenever the operation queue has room.
  assign accept = in_push && !in_full;

  pmsc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .op     (fe_op)
  );

  pmsc_opq u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_push),
    .wr_op      (fe_op),
    .full       (in_full),
    .rd_en      (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pmsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_pop    (out_pop),
    .res_empty  (out_empty),
    .res        (res)
  );

  assign out_pixel_byte = res.pixel_byte;
  assign out_page       = res.page;
  assign out_column     = res.column;
  assign out_frame_end  = res.frame_end;

endmodule
